/* rtl/core/ordered_array_insert_delete_defines.svh */
// Assertion macros shared by the ordered array blocks.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ORDERED_ARRAY_INSERT_DELETE_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define OAID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that post holds in the cycle after pre.
`define OAID_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/oaid_pkg.sv */
// Package for the ordered array block: sizes, operation and status codes,
// and the command and status structs between controller and datapath. No dependencies.
package oaid_pkg;

  localparam int CAPACITY  = 64;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;
  localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_REMOVE = 3'd2,
    FN_FIND   = 3'd3,
    FN_READ   = 3'd4,
    FN_WRITE  = 3'd5,
    FN_CLEAR  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_APPEND,
    DP_INS_INIT,
    DP_SHIFT_RD_UP,
    DP_SHIFT_WR_UP,
    DP_INS_FINAL,
    DP_REM_INIT,
    DP_SHIFT_RD_DN,
    DP_SHIFT_WR_DN,
    DP_REM_FINAL,
    DP_FIND_INIT,
    DP_FIND_RD,
    DP_FIND_CMP,
    DP_READ_RD,
    DP_READ_CAP,
    DP_WRITE,
    DP_CLEAR,
    DP_SET_RANGE,
    DP_SET_FULL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       idx_lt_cnt;
    logic       idx_zero;
    logic       full;
    logic       ptr_gt_idx;
    logic       ptr_next_lt_cnt;
    logic       ptr_lt_cnt;
    logic       match;
    logic       out_free;
  } dp_stat_t;

endpackage

/* rtl/core/oaid_ctrl.sv */
// Controller state machine for the ordered array block.
// Depends on oaid_pkg and ordered_array_insert_delete_defines.svh.
`include "ordered_array_insert_delete_defines.svh"

module oaid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  oaid_pkg::dp_stat_t stat,
  output oaid_pkg::dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DECODE   = 10'b00_0000_0010,
    S_INS_CHK  = 10'b00_0000_0100,
    S_INS_WR   = 10'b00_0000_1000,
    S_REM_CHK  = 10'b00_0001_0000,
    S_REM_WR   = 10'b00_0010_0000,
    S_FIND_CHK = 10'b00_0100_0000,
    S_FIND_CMP = 10'b00_1000_0000,
    S_READ_CAP = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No beat is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next   = state;
    cmd.op       = oaid_pkg::DP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = oaid_pkg::DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        case (stat.func)
          oaid_pkg::FN_APPEND: begin
            cmd.op = stat.full ? oaid_pkg::DP_SET_FULL : oaid_pkg::DP_APPEND;
          end
          oaid_pkg::FN_INSERT: begin
            if (!(stat.idx_lt_cnt || stat.idx_zero)) begin
              cmd.op = oaid_pkg::DP_SET_RANGE;
            end else if (stat.full) begin
              cmd.op = oaid_pkg::DP_SET_FULL;
            end else begin
              cmd.op     = oaid_pkg::DP_INS_INIT;
              state_next = S_INS_CHK;
            end
          end
          oaid_pkg::FN_REMOVE: begin
            if (!stat.idx_lt_cnt) begin
              cmd.op = oaid_pkg::DP_SET_RANGE;
            end else begin
              cmd.op     = oaid_pkg::DP_REM_INIT;
              state_next = S_REM_CHK;
            end
          end
          oaid_pkg::FN_FIND: begin
            cmd.op     = oaid_pkg::DP_FIND_INIT;
            state_next = S_FIND_CHK;
          end
          oaid_pkg::FN_READ: begin
            if (!stat.idx_lt_cnt) begin
              cmd.op = oaid_pkg::DP_SET_RANGE;
            end else begin
              cmd.op     = oaid_pkg::DP_READ_RD;
              state_next = S_READ_CAP;
            end
          end
          oaid_pkg::FN_WRITE: begin
            cmd.op = stat.idx_lt_cnt ? oaid_pkg::DP_WRITE : oaid_pkg::DP_SET_RANGE;
          end
          oaid_pkg::FN_CLEAR: begin
            cmd.op = oaid_pkg::DP_CLEAR;
          end
          default: begin
            cmd.op = oaid_pkg::DP_NONE;
          end
        endcase
      end
      S_INS_CHK: begin
        if (stat.ptr_gt_idx) begin
          cmd.op     = oaid_pkg::DP_SHIFT_RD_UP;
          state_next = S_INS_WR;
        end else begin
          cmd.op     = oaid_pkg::DP_INS_FINAL;
          state_next = S_FINISH;
        end
      end
      S_INS_WR: begin
        cmd.op     = oaid_pkg::DP_SHIFT_WR_UP;
        state_next = S_INS_CHK;
      end
      S_REM_CHK: begin
        if (stat.ptr_next_lt_cnt) begin
          cmd.op     = oaid_pkg::DP_SHIFT_RD_DN;
          state_next = S_REM_WR;
        end else begin
          cmd.op     = oaid_pkg::DP_REM_FINAL;
          state_next = S_FINISH;
        end
      end
      S_REM_WR: begin
        cmd.op     = oaid_pkg::DP_SHIFT_WR_DN;
        state_next = S_REM_CHK;
      end
      S_FIND_CHK: begin
        if (stat.ptr_lt_cnt) begin
          cmd.op     = oaid_pkg::DP_FIND_RD;
          state_next = S_FIND_CMP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FIND_CMP: begin
        cmd.op     = oaid_pkg::DP_FIND_CMP;
        state_next = stat.match ? S_FINISH : S_FIND_CHK;
      end
      S_READ_CAP: begin
        cmd.op     = oaid_pkg::DP_READ_CAP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // The result waits here until the output register is free.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `OAID_ASSERT_NEXT(a_one_beat_at_a_time, in_valid && in_ready, !in_ready, "second beat accepted while busy")
  `OAID_ASSERT(a_shift_up_pairs, cmd.op != oaid_pkg::DP_SHIFT_WR_UP || $past(cmd.op) == oaid_pkg::DP_SHIFT_RD_UP, "shift-up write without preceding read")
  `OAID_ASSERT(a_shift_dn_pairs, cmd.op != oaid_pkg::DP_SHIFT_WR_DN || $past(cmd.op) == oaid_pkg::DP_SHIFT_RD_DN, "shift-down write without preceding read")

endmodule

/* rtl/core/oaid_dp.sv */
// Datapath for the ordered array block: entry memory, count, scan pointer,
// result and output registers. Depends on oaid_pkg and the defines header.
`include "ordered_array_insert_delete_defines.svh"

module oaid_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  oaid_pkg::dp_cmd_t                      cmd,
  output oaid_pkg::dp_stat_t                     stat,
  input  logic [2:0]                             func,
  input  logic [oaid_pkg::IDX_W-1:0]             index,
  input  logic signed [oaid_pkg::VAL_W-1:0]      value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [oaid_pkg::VAL_W-1:0]      read_value,
  output logic                                   found,
  output logic [oaid_pkg::CNT_OUT_W-1:0]         count,
  output logic [1:0]                             status
);

  logic signed [oaid_pkg::VAL_W-1:0] mem [oaid_pkg::CAPACITY];
  logic signed [oaid_pkg::VAL_W-1:0] rdata;

  logic [oaid_pkg::CNT_W-1:0]        cnt;
  logic [oaid_pkg::CNT_W-1:0]        ptr;
  logic [2:0]                        func_q;
  logic [oaid_pkg::IDX_W-1:0]        idx_q;
  logic signed [oaid_pkg::VAL_W-1:0] val_q;
  logic signed [oaid_pkg::VAL_W-1:0] res_rd;
  logic                              res_found;
  oaid_pkg::status_t                 res_status;

  logic                              rd_en;
  logic [oaid_pkg::ADDR_W-1:0]       rd_addr;
  logic                              wr_en;
  logic [oaid_pkg::ADDR_W-1:0]       wr_addr;
  logic signed [oaid_pkg::VAL_W-1:0] wr_data;
  logic [oaid_pkg::CNT_W-1:0]        ptr_inc;

  assign ptr_inc = ptr + 1'b1;

  assign stat.func            = func_q;
  assign stat.idx_lt_cnt      = oaid_pkg::CMP_W'(idx_q) < oaid_pkg::CMP_W'(cnt);
  assign stat.idx_zero        = (idx_q == '0);
  assign stat.full            = (cnt >= oaid_pkg::CNT_W'(oaid_pkg::CAPACITY));
  assign stat.ptr_gt_idx      = oaid_pkg::CMP_W'(ptr) > oaid_pkg::CMP_W'(idx_q);
  assign stat.ptr_next_lt_cnt = (ptr_inc < cnt);
  assign stat.ptr_lt_cnt      = (ptr < cnt);
  assign stat.match           = (rdata == val_q);
  assign stat.out_free        = !out_valid || out_ready;

  // Memory port selection. Reads are registered, so each shift step is
  // a read in one cycle and the write of that word in the next.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = val_q;
    case (cmd.op)
      oaid_pkg::DP_SHIFT_RD_UP: begin
        rd_en   = 1'b1;
        rd_addr = oaid_pkg::ADDR_W'(ptr - 1'b1);
      end
      oaid_pkg::DP_SHIFT_RD_DN: begin
        rd_en   = 1'b1;
        rd_addr = oaid_pkg::ADDR_W'(ptr_inc);
      end
      oaid_pkg::DP_FIND_RD: begin
        rd_en   = 1'b1;
        rd_addr = oaid_pkg::ADDR_W'(ptr);
      end
      oaid_pkg::DP_READ_RD: begin
        rd_en   = 1'b1;
        rd_addr = oaid_pkg::ADDR_W'(idx_q);
      end
      oaid_pkg::DP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = oaid_pkg::ADDR_W'(cnt);
      end
      oaid_pkg::DP_SHIFT_WR_UP, oaid_pkg::DP_SHIFT_WR_DN: begin
        wr_en   = 1'b1;
        wr_addr = oaid_pkg::ADDR_W'(ptr);
        wr_data = rdata;
      end
      oaid_pkg::DP_INS_FINAL, oaid_pkg::DP_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = oaid_pkg::ADDR_W'(idx_q);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        oaid_pkg::DP_APPEND, oaid_pkg::DP_INS_FINAL: cnt <= cnt + 1'b1;
        oaid_pkg::DP_REM_FINAL:                      cnt <= cnt - 1'b1;
        oaid_pkg::DP_CLEAR:                          cnt <= '0;
        default:                                     cnt <= cnt;
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      oaid_pkg::DP_LOAD: begin
        func_q     <= func;
        idx_q      <= index;
        val_q      <= value;
        res_rd     <= '0;
        res_found  <= 1'b0;
        res_status <= oaid_pkg::ST_OK;
      end
      oaid_pkg::DP_INS_INIT:    ptr <= cnt;
      oaid_pkg::DP_SHIFT_WR_UP: ptr <= ptr - 1'b1;
      oaid_pkg::DP_REM_INIT:    ptr <= oaid_pkg::CNT_W'(idx_q);
      oaid_pkg::DP_SHIFT_WR_DN: ptr <= ptr_inc;
      oaid_pkg::DP_FIND_INIT:   ptr <= '0;
      oaid_pkg::DP_FIND_RD:     ptr <= ptr_inc;
      oaid_pkg::DP_FIND_CMP:    res_found <= stat.match;
      oaid_pkg::DP_READ_CAP:    res_rd <= rdata;
      oaid_pkg::DP_SET_RANGE:   res_status <= oaid_pkg::ST_RANGE;
      oaid_pkg::DP_SET_FULL:    res_status <= oaid_pkg::ST_FULL;
      default:                  ptr <= ptr;
    endcase
    if (cmd.out_load) begin
      read_value <= res_rd;
      found      <= res_found;
      count      <= oaid_pkg::CNT_OUT_W'(cnt);
      status     <= res_status;
    end
  end

  `OAID_ASSERT(a_count_bounded, cnt <= oaid_pkg::CNT_W'(oaid_pkg::CAPACITY), "entry count above capacity")
  `OAID_ASSERT(a_load_when_free, !cmd.out_load || stat.out_free, "result loaded over an untaken beat")

endmodule

/* rtl/core/ordered_array_insert_delete.sv */
// Top level of the ordered array block: controller and datapath.
// Depends on oaid_pkg, oaid_ctrl and oaid_dp.
//
// Channel  Handshake             Payload
// in       in_valid / in_ready   func, index, value
// out      out_valid / out_ready read_value, found, count, status
//
// Append, write, clear, full and out-of-range cases finish straight after decode; read
// adds a registered read of the entry. Insert at index i shifts the entries from the end
// down to i up by one, remove shifts those above i down by one, and find scans from 0 to a match.
// The memory, one access a cycle with a registered read, moves a word by a read then a write.
// A new beat is accepted the cycle after the previous result enters the output
// register. Reset clears the count and control only; entry contents stay as they are.
// While out_ready is low the finished result holds and the next result waits.
module ordered_array_insert_delete (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        func,
  input  logic [oaid_pkg::IDX_W-1:0]        index,
  input  logic signed [oaid_pkg::VAL_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [oaid_pkg::VAL_W-1:0] read_value,
  output logic                              found,
  output logic [oaid_pkg::CNT_OUT_W-1:0]    count,
  output logic [1:0]                        status
);

  oaid_pkg::dp_cmd_t  cmd;
  oaid_pkg::dp_stat_t stat;

  oaid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  oaid_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .func       (func),
    .index      (index),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .found      (found),
    .count      (count),
    .status     (status)
  );

endmodule

/* tb/oaid_list_checker.sv */
// Result checker for ordered_array_insert_delete: keeps its own copy of the list,
// predicts one result per accepted input beat and compares it with the output beats.
// Depends on oaid_pkg.
module oaid_list_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [2:0]                        func,
  input  logic [oaid_pkg::IDX_W-1:0]        index,
  input  logic signed [oaid_pkg::VAL_W-1:0] value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [oaid_pkg::VAL_W-1:0] read_value,
  input  logic                              found,
  input  logic [oaid_pkg::CNT_OUT_W-1:0]    count,
  input  logic [1:0]                        status,
  output int                                fail_count,
  output int                                pending,
  output int                                stored_len
);

  localparam int CHK_W = oaid_pkg::VAL_W + 1;

  typedef struct packed {
    logic signed [oaid_pkg::VAL_W-1:0] read_value;
    logic                              found;
    logic [oaid_pkg::CNT_OUT_W-1:0]    count;
    oaid_pkg::status_t                 status;
  } list_result_t;

  logic signed [oaid_pkg::VAL_W-1:0] list_words [oaid_pkg::CAPACITY];
  int                                list_len = 0;
  int                                mismatches = 0;
  list_result_t                      result_queue [$];

  // Applies one operation to the shadow list and returns the result it should produce.
  function automatic list_result_t run_list_op(input logic [2:0] op,
                                               input logic [oaid_pkg::IDX_W-1:0] pos,
                                               input logic signed [oaid_pkg::VAL_W-1:0] word);
    list_result_t res;
    res = '0;
    res.status = oaid_pkg::ST_OK;
    case (op)
      oaid_pkg::FN_APPEND: begin
        if (list_len >= oaid_pkg::CAPACITY) begin
          res.status = oaid_pkg::ST_FULL;
        end else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      oaid_pkg::FN_INSERT: begin
        // The range check wins over the full check.
        if (!(pos < list_len || pos == 0)) begin
          res.status = oaid_pkg::ST_RANGE;
        end else if (list_len >= oaid_pkg::CAPACITY) begin
          res.status = oaid_pkg::ST_FULL;
        end else begin
          for (int k = list_len; k > pos; k--) list_words[k] = list_words[k - 1];
          list_words[pos] = word;
          list_len++;
        end
      end
      oaid_pkg::FN_REMOVE: begin
        if (pos >= list_len) begin
          res.status = oaid_pkg::ST_RANGE;
        end else begin
          for (int k = pos; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
          list_len--;
        end
      end
      oaid_pkg::FN_FIND: begin
        for (int k = 0; k < list_len; k++) begin
          if (list_words[k] == word) res.found = 1'b1;
        end
      end
      oaid_pkg::FN_READ: begin
        if (pos >= list_len) res.status = oaid_pkg::ST_RANGE;
        else res.read_value = list_words[pos];
      end
      oaid_pkg::FN_WRITE: begin
        if (pos >= list_len) res.status = oaid_pkg::ST_RANGE;
        else list_words[pos] = word;
      end
      oaid_pkg::FN_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.count = oaid_pkg::CNT_OUT_W'(list_len);
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [CHK_W-1:0] want_v,
                             input logic signed [CHK_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len = 0;
      result_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $error("result beat with nothing expected: read_value %0d count %0d status %0d",
                 read_value, count, status);
          mismatches++;
        end else begin
          want = result_queue.pop_front();
          check_field("read_value", CHK_W'($signed(want.read_value)),
                      CHK_W'($signed(read_value)));
          check_field("found", CHK_W'(want.found), CHK_W'(found));
          check_field("count", CHK_W'(want.count), CHK_W'(count));
          check_field("status", CHK_W'(want.status), CHK_W'(status));
        end
      end
      if (in_valid && in_ready) result_queue.push_back(run_list_op(func, index, value));
    end
    fail_count <= mismatches;
    pending    <= result_queue.size();
    stored_len <= list_len;
  end

  final begin
    if (result_queue.size() != 0) $error("%0d results never arrived", result_queue.size());
  end
endmodule

/* tb/ordered_array_insert_delete_tb.sv */
// Testbench top for ordered_array_insert_delete: clock, reset, directed and random beats
// with sender gaps and receiver stalls, and the verdict. Uses oaid_pkg and oaid_list_checker.
module ordered_array_insert_delete_tb;

  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1330;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 160;
  localparam logic signed [oaid_pkg::VAL_W-1:0] WORD_MAX =
    {1'b0, {(oaid_pkg::VAL_W - 1){1'b1}}};
  localparam logic signed [oaid_pkg::VAL_W-1:0] WORD_MIN =
    {1'b1, {(oaid_pkg::VAL_W - 1){1'b0}}};

  typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} load_phase_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [2:0]                        func = oaid_pkg::FN_APPEND;
  logic [oaid_pkg::IDX_W-1:0]        index = '0;
  logic signed [oaid_pkg::VAL_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [oaid_pkg::VAL_W-1:0] read_value;
  logic                              found;
  logic [oaid_pkg::CNT_OUT_W-1:0]    count;
  logic [1:0]                        status;
  int                                fail_count;
  int                                pending;
  int                                stored_len;
  int                                idle_cycles = 0;
  int                                rx_hold = 0;

  always #6 clk = ~clk;

  ordered_array_insert_delete dut (
    .clk, .rst, .in_valid, .in_ready, .func, .index, .value,
    .out_valid, .out_ready, .read_value, .found, .count, .status
  );

  oaid_list_checker list_check (
    .clk, .rst, .in_valid, .in_ready, .func, .index, .value,
    .out_valid, .out_ready, .read_value, .found, .count, .status,
    .fail_count, .pending, .stored_len
  );

  // Holds one input beat until it is accepted; returns at the accepting edge.
  task automatic send_beat(input logic [2:0] op, input logic [oaid_pkg::IDX_W-1:0] pos,
                           input logic signed [oaid_pkg::VAL_W-1:0] word);
    in_valid <= 1'b1;
    func     <= op;
    index    <= pos;
    value    <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly in range, often just past the end, sometimes anywhere.
  function automatic logic [oaid_pkg::IDX_W-1:0] pick_index(input int len);
    int roll;
    roll = $urandom_range(99);
    if (roll < 75 && len > 0) return oaid_pkg::IDX_W'($urandom_range(len - 1, 0));
    if (roll < 88) begin
      return (len > oaid_pkg::CAPACITY - 1) ? oaid_pkg::IDX_W'(oaid_pkg::CAPACITY - 1)
                                            : oaid_pkg::IDX_W'(len);
    end
    return oaid_pkg::IDX_W'($urandom_range(2 ** oaid_pkg::IDX_W - 1));
  endfunction

  // A small pool of values keeps searches hitting now and then.
  function automatic logic signed [oaid_pkg::VAL_W-1:0] pick_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return oaid_pkg::VAL_W'($urandom_range(15)) - oaid_pkg::VAL_W'(8);
      4: return WORD_MIN;
      5: return WORD_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input load_phase_t ph);
    int roll;
    roll = $urandom_range(99);
    case (ph)
      PH_GROW: begin
        if (roll < 35) return oaid_pkg::FN_APPEND;
        if (roll < 65) return oaid_pkg::FN_INSERT;
        if (roll < 70) return oaid_pkg::FN_REMOVE;
        if (roll < 80) return oaid_pkg::FN_FIND;
        if (roll < 90) return oaid_pkg::FN_READ;
        return oaid_pkg::FN_WRITE;
      end
      PH_SHRINK: begin
        if (roll < 5) return oaid_pkg::FN_APPEND;
        if (roll < 10) return oaid_pkg::FN_INSERT;
        if (roll < 63) return oaid_pkg::FN_REMOVE;
        if (roll < 73) return oaid_pkg::FN_FIND;
        if (roll < 86) return oaid_pkg::FN_READ;
        if (roll < 98) return oaid_pkg::FN_WRITE;
        return oaid_pkg::FN_CLEAR;
      end
      default: begin
        if (roll < 16) return oaid_pkg::FN_APPEND;
        if (roll < 32) return oaid_pkg::FN_INSERT;
        if (roll < 48) return oaid_pkg::FN_REMOVE;
        if (roll < 64) return oaid_pkg::FN_FIND;
        if (roll < 78) return oaid_pkg::FN_READ;
        if (roll < 92) return oaid_pkg::FN_WRITE;
        if (roll < 97) return oaid_pkg::FN_CLEAR;
        return FN_UNUSED;
      end
    endcase
  endfunction

  // Receiver: ready and stall runs of random length, with occasional long ready stretches.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      rx_hold <= ($urandom_range(3) == 0) ? $urandom_range(20, 8) : $urandom_range(4, 0);
    end else begin
      out_ready <= 1'b1;
      rx_hold <= ($urandom_range(4) == 0) ? $urandom_range(300, 100) : $urandom_range(12, 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    load_phase_t phase;
    int          phase_left;
    int          burst_left;
    int          gap;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty list: every indexed operation is out of range, search finds nothing.
    send_beat(oaid_pkg::FN_READ, '0, '0);
    send_beat(oaid_pkg::FN_REMOVE, '0, '0);
    send_beat(oaid_pkg::FN_WRITE, '0, oaid_pkg::VAL_W'(1));
    send_beat(oaid_pkg::FN_FIND, '0, '0);
    send_beat(oaid_pkg::FN_INSERT, oaid_pkg::IDX_W'(1), oaid_pkg::VAL_W'(5));
    // Insert at zero is the one index allowed on an empty list.
    send_beat(oaid_pkg::FN_INSERT, '0, WORD_MAX);
    send_beat(oaid_pkg::FN_INSERT, oaid_pkg::IDX_W'(1), oaid_pkg::VAL_W'(5));
    send_beat(oaid_pkg::FN_APPEND, '0, WORD_MIN);
    send_beat(oaid_pkg::FN_INSERT, oaid_pkg::IDX_W'(1), '1);
    send_beat(oaid_pkg::FN_INSERT, '0, '0);
    for (int k = 0; k < 4; k++) send_beat(oaid_pkg::FN_READ, oaid_pkg::IDX_W'(k), '0);
    send_beat(oaid_pkg::FN_READ, '1, '0);
    send_beat(oaid_pkg::FN_WRITE, oaid_pkg::IDX_W'(3), 32'h5555_5555);
    send_beat(oaid_pkg::FN_WRITE, oaid_pkg::IDX_W'(4), oaid_pkg::VAL_W'(7));
    send_beat(oaid_pkg::FN_FIND, '0, 32'h5555_5555);
    send_beat(oaid_pkg::FN_FIND, '0, WORD_MIN);
    send_beat(oaid_pkg::FN_FIND, '1, 32'hAAAA_AAAA);
    send_beat(oaid_pkg::FN_REMOVE, oaid_pkg::IDX_W'(4), '0);
    send_beat(oaid_pkg::FN_REMOVE, '0, '0);
    send_beat(oaid_pkg::FN_REMOVE, oaid_pkg::IDX_W'(2), '0);
    send_beat(FN_UNUSED, '1, WORD_MAX);
    send_beat(oaid_pkg::FN_CLEAR, '0, '0);
    send_beat(oaid_pkg::FN_READ, '0, '0);

    // The first phase grows long enough to fill the store.
    phase = PH_GROW;
    phase_left = 130;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase = load_phase_t'($urandom_range(2));
        phase_left = $urandom_range(120, 30);
      end
      phase_left--;
      if (burst_left == 0) begin
        case ($urandom_range(9))
          0, 1, 2: gap = 0;
          3: gap = $urandom_range(40, 9);
          default: gap = $urandom_range(8, 1);
        endcase
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(5) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
      end
      burst_left--;
      send_beat(pick_op(phase), pick_index(stored_len), pick_word());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
